// ===== src/sdes_pkg.sv =====
// ----------------------------------------------------------------------------
// sdes_pkg: shared types, constants and functions for the s-des cbc cipher
// Key schedule selections, permutations, s-boxes and the keyed round fK.
// Bit numbering is lsb-first throughout.
// ----------------------------------------------------------------------------
package sdes_pkg;

  localparam int KEY_W   = 10;
  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 10;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_KEY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_IV   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = 2'd2;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [1:0]        sbox_val_t;

  // configuration seen by the cipher datapath
  typedef struct packed {
    key_t  key;
    byte_t iv;
    logic  decrypt;
  } cfg_t;

  // s-boxes, indexed [row][col]
  localparam sbox_val_t SBOX0 [0:3][0:3] = '{
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd2, 2'd1, 2'd3},
    '{2'd3, 2'd1, 2'd3, 2'd2}
  };
  localparam sbox_val_t SBOX1 [0:3][0:3] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd1, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd3}
  };

  // first round key: key bits 4,0,7,2,6,1,3,9 into bits 0..7
  function automatic byte_t first_subkey(key_t k);
    return {k[9], k[3], k[1], k[6], k[2], k[7], k[0], k[4]};
  endfunction

  // second round key: key bits 9,1,8,0,5,4,7,2 into bits 0..7
  function automatic byte_t second_subkey(key_t k);
    return {k[2], k[7], k[4], k[5], k[0], k[8], k[1], k[9]};
  endfunction

  // initial permutation: source bits 1,3,0,4,7,5,2,6
  function automatic byte_t perm_ip(byte_t v);
    return {v[6], v[2], v[5], v[7], v[4], v[0], v[3], v[1]};
  endfunction

  // inverse permutation: source bits 2,0,6,1,3,5,7,4
  function automatic byte_t perm_ip_inv(byte_t v);
    return {v[4], v[7], v[5], v[3], v[1], v[6], v[0], v[2]};
  endfunction

  function automatic byte_t swap_nibbles(byte_t v);
    return {v[3:0], v[7:4]};
  endfunction

  // keyed round: expand low nibble, mix with subkey, s-boxes, fold into high nibble
  function automatic byte_t round_fk(byte_t subkey, byte_t blk);
    byte_t     ep;
    sbox_val_t e0;
    sbox_val_t e1;
    ep = {blk[0], blk[3], blk[2], blk[1], blk[2], blk[1], blk[0], blk[3]} ^ subkey;
    e0 = SBOX0[{ep[7], ep[4]}][{ep[6], ep[5]}];
    e1 = SBOX1[{ep[3], ep[0]}][{ep[2], ep[1]}];
    return blk ^ {e0[0], e1[0], e1[1], e0[1], 4'b0000};
  endfunction

endpackage

// ===== src/sdes_if.sv =====
// ----------------------------------------------------------------------------
// sdes_in_if / sdes_out_if: valid/ready channels of the s-des cbc cipher
// The input carries a byte and a message start flag, the output one byte.
// ----------------------------------------------------------------------------
interface sdes_in_if;
  logic                       valid;
  logic                       ready;
  logic [sdes_pkg::BYTE_W-1:0] data_in;
  logic                       message_start;

  modport source (output valid, output data_in, output message_start, input ready);
  modport sink   (input valid, input data_in, input message_start, output ready);
endinterface

interface sdes_out_if;
  logic                       valid;
  logic                       ready;
  logic [sdes_pkg::BYTE_W-1:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

// ===== src/sdes_cbc_byte_cipher.sv =====
// ----------------------------------------------------------------------------
// sdes_cbc_byte_cipher: byte-wide simplified des in cipher block chaining mode
//
// Usage:
//   in_ch  carries data_in and message_start; an item moves when valid and
//          ready are both high at a rising edge of clk.
//   out_ch carries data_out, one result item for every input item, in order.
//   cfg_we/cfg_index/cfg_wdata write the key (0), iv (1) and decrypt mode (2)
//   while the block is idle; other indexes are ignored.
// An item passes an input register, then the cipher and chaining logic, then
//   the output register, which drives out_ch.valid.
// Throughput is one byte per cycle while out_ch.ready is high; the chaining
//   byte is updated in the same cycle as the output register loads, so the
//   next byte sees it at once.
// Reset (rst_n low, synchronous) clears both stages, the chaining byte and
//   all configuration registers.
// When out_ch.ready is low the result holds in the output register and one
//   more item can wait in the input register; in_ch.ready then drops.
// ----------------------------------------------------------------------------
module sdes_cbc_byte_cipher (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sdes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sdes_pkg::CFG_W-1:0]          cfg_wdata,
  sdes_in_if.sink                             in_ch,
  sdes_out_if.source                          out_ch
);

  sdes_pkg::cfg_t  cfg_r;
  sdes_pkg::byte_t chain_r;
  sdes_pkg::byte_t chain_nxt;
  sdes_pkg::byte_t s1_data_r;
  logic            s1_start_r;
  logic            s1_valid_r;
  sdes_pkg::byte_t out_data_r;
  sdes_pkg::byte_t out_data_nxt;
  logic            out_valid_r;
  logic            out_free;
  logic            advance;
  logic            in_take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdes_pkg::CFG_IDX_KEY:  cfg_r.key     <= cfg_wdata[sdes_pkg::KEY_W-1:0];
        sdes_pkg::CFG_IDX_IV:   cfg_r.iv      <= cfg_wdata[sdes_pkg::BYTE_W-1:0];
        sdes_pkg::CFG_IDX_MODE: cfg_r.decrypt <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_take     = in_ch.valid && in_ch.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r  <= in_ch.data_in;
      s1_start_r <= in_ch.message_start;
    end
  end

  // cipher datapath
  sdes_cipher u_cipher (
    .cfg           (cfg_r),
    .data          (s1_data_r),
    .message_start (s1_start_r),
    .chain         (chain_r),
    .result        (out_data_nxt),
    .chain_nxt     (chain_nxt)
  );

  // chaining byte and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        chain_r <= chain_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.data_out = out_data_r;

  // a waiting item is not dropped while the output is stalled
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("input stage item lost during stall");

  // chaining byte changes only when an item moves to the output
  a_chain_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(chain_r))
    else $error("chaining byte changed without an item");

  // encryption chains on the ciphertext just produced
  a_enc_chain: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !cfg_r.decrypt |=> chain_r == out_data_r)
    else $error("encrypt chaining byte differs from ciphertext");

  // decryption chains on the ciphertext input
  a_dec_chain: assert property (@(posedge clk) disable iff (!rst_n)
    advance && cfg_r.decrypt |=> chain_r == $past(s1_data_r))
    else $error("decrypt chaining byte differs from input byte");

endmodule

// ===== src/sdes_cipher.sv =====
// ----------------------------------------------------------------------------
// sdes_cipher: one-pass cbc cipher datapath
// Key schedule, chaining xor and both rounds of s-des for one byte,
// with the next chaining byte for the item.
// ----------------------------------------------------------------------------
module sdes_cipher (
  input  sdes_pkg::cfg_t  cfg,
  input  sdes_pkg::byte_t data,
  input  logic            message_start,
  input  sdes_pkg::byte_t chain,
  output sdes_pkg::byte_t result,
  output sdes_pkg::byte_t chain_nxt
);

  sdes_pkg::byte_t k1;
  sdes_pkg::byte_t k2;
  sdes_pkg::byte_t first_key;
  sdes_pkg::byte_t second_key;
  sdes_pkg::byte_t chain_use;
  sdes_pkg::byte_t blk_in;
  sdes_pkg::byte_t t_ip;
  sdes_pkg::byte_t t_r1;
  sdes_pkg::byte_t t_r2;
  sdes_pkg::byte_t core_out;

  // subkeys, swapped for decryption
  assign k1         = sdes_pkg::first_subkey(cfg.key);
  assign k2         = sdes_pkg::second_subkey(cfg.key);
  assign first_key  = cfg.decrypt ? k2 : k1;
  assign second_key = cfg.decrypt ? k1 : k2;

  // chaining byte restarts from the iv at message start
  assign chain_use = message_start ? cfg.iv : chain;

  // encryption xors before the cipher
  assign blk_in = cfg.decrypt ? data : (data ^ chain_use);

  // ip, fK, swap, fK, ip inverse
  assign t_ip     = sdes_pkg::perm_ip(blk_in);
  assign t_r1     = sdes_pkg::round_fk(first_key, t_ip);
  assign t_r2     = sdes_pkg::round_fk(second_key, sdes_pkg::swap_nibbles(t_r1));
  assign core_out = sdes_pkg::perm_ip_inv(t_r2);

  // decryption xors after the cipher and chains on the ciphertext input
  assign result    = cfg.decrypt ? (core_out ^ chain_use) : core_out;
  assign chain_nxt = cfg.decrypt ? data : core_out;

endmodule
